// ===== rtl/assert_macros.svh =====
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with active-low reset gating
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/lwd_pkg.sv =====
// ----------------------------------------------------------------------------
// lwd_pkg
// types and constants for the ledbat++ window change pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lwd_pkg;

    localparam int unsigned WIN_W   = 16;
    localparam int unsigned SCALE_W = 15;
    localparam int unsigned QD_W    = 24;
    localparam int unsigned RTT_W   = 32;
    localparam int unsigned TGT_W   = 16;
    localparam int unsigned GL_W    = 8;
    localparam int unsigned CHG_W   = 32;

    localparam int unsigned WS_W    = WIN_W + SCALE_W;        // scaled window
    localparam int unsigned DIFF_W  = QD_W + 1;               // signed delay error
    localparam int unsigned GREM_W  = TGT_W + 1;              // 2*target - 1
    localparam int unsigned GCMP_W  = RTT_W + GL_W;           // rtt << 8
    localparam int unsigned P1_W    = GL_W + WS_W;            // gain * ws
    localparam int unsigned ACC_W   = 64;
    localparam int unsigned DEN_W   = GL_W + TGT_W;
    localparam int unsigned QLO_W   = 32;                     // quotient bits kept

    localparam int unsigned REG_TARGET = 0;
    localparam int unsigned REG_GAIN   = 1;

    localparam logic [TGT_W-1:0] TARGET_RESET = 16'd360;
    localparam logic [GL_W-1:0]  GAIN_RESET   = 8'd16;

    // stage layout
    localparam int unsigned GDIV_STAGES = 4;
    localparam int unsigned GDIV_STEPS  = GL_W / GDIV_STAGES;
    localparam int unsigned DIV_STAGES  = 8;
    localparam int unsigned DIV_STEPS   = QLO_W / DIV_STAGES;
    localparam int unsigned ST_GAIN     = 1 + GDIV_STAGES;
    localparam int unsigned ST_P1       = ST_GAIN + 1;
    localparam int unsigned ST_P2       = ST_P1 + 1;
    localparam int unsigned ST_NUM      = ST_P2 + 1;
    localparam int unsigned ST_DIV0     = ST_NUM + 1;
    localparam int unsigned ST_FINAL    = ST_DIV0 + DIV_STAGES;
    localparam int unsigned NSTAGE      = ST_FINAL + 1;

    localparam logic signed [CHG_W-1:0] CHG_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic [WS_W-1:0]          ws;
        logic signed [DIFF_W-1:0] diff;
        logic [TGT_W-1:0]         tgt;
        logic [GL_W-1:0]          gl;
        logic [RTT_W-1:0]         rtt;
        logic [GREM_W-1:0]        grem;
        logic [GL_W-1:0]          gq;
        logic                     gsat;
        logic [GL_W-1:0]          gain;
        logic signed [ACC_W-1:0]  acc;
        logic [DEN_W-1:0]         den;
        logic                     neg;
        logic                     dzero;
        logic                     qsat;
        logic [DEN_W-1:0]         rem;
        logic [QLO_W-1:0]         qlo;
        logic [CHG_W-1:0]         res;
    } stage_t;

endpackage

// ===== rtl/ledbat_window_decrease_top.sv =====
// ----------------------------------------------------------------------------
// ledbat_window_decrease_top
// stages in order: input, gain divider, gain clamp, first and second product, numerator, main divider, final
// throughput: one transaction per cycle; the whole pipe holds on output stall
// gain divider takes two restoring steps per stage, main divider four per stage
// reset: valid bits cleared, target_delay = 360, gain_limit = 16
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ledbat_window_decrease_top
    import lwd_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic                     cfg_index,
    input  logic [TGT_W-1:0]         cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [WIN_W-1:0]         s_window,
    input  logic [SCALE_W-1:0]       s_scale,
    input  logic [QD_W-1:0]          s_qdelay,
    input  logic [RTT_W-1:0]         s_rtt_min,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [CHG_W-1:0]  m_window_change
);

    logic [TGT_W-1:0] target_reg;
    logic [GL_W-1:0]  gain_limit_reg;
    stage_t           st_reg  [NSTAGE];
    stage_t           st_next [NSTAGE];
    logic [NSTAGE-1:0] vld_reg;
    logic             adv;

    assign adv             = !vld_reg[NSTAGE-1] || m_ready;
    assign s_ready         = adv;
    assign m_valid         = vld_reg[NSTAGE-1];
    assign m_window_change = st_reg[NSTAGE-1].res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg     <= TARGET_RESET;
            gain_limit_reg <= GAIN_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                1'(REG_TARGET): target_reg     <= cfg_wdata;
                1'(REG_GAIN):   gain_limit_reg <= cfg_wdata[GL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        stage_t                s;
        logic [GCMP_W-1:0]     cmp;
        logic [GL_W:0]         ceil9;
        logic [DEN_W:0]        rem2;
        logic [ACC_W-1:0]      mag;
        logic [P1_W:0]         p1s;
        logic [WS_W-2:0]       half_mag;
        int                    k;

        // input stage
        s        = st_reg[0];
        s.ws     = WS_W'(s_window * s_scale);
        s.diff   = $signed({1'b0, s_qdelay}) - $signed({9'b0, target_reg});
        s.tgt    = target_reg;
        s.gl     = gain_limit_reg;
        s.rtt    = s_rtt_min;
        s.grem   = {target_reg, 1'b0} - GREM_W'(1);
        cmp      = {s_rtt_min, {GL_W{1'b0}}};
        s.gsat   = cmp <= GCMP_W'(s.grem);
        s.gq     = '0;
        st_next[0] = s;

        for (int i = 1; i < NSTAGE; i++) begin
            st_next[i] = st_reg[i-1];
        end

        // gain divider: floor((2t-1)/rtt), two quotient bits per stage
        for (int g = 0; g < GDIV_STAGES; g++) begin
            s = st_reg[g];
            for (int j = 0; j < GDIV_STEPS; j++) begin
                k   = GL_W - 1 - GDIV_STEPS * g - j;
                cmp = GCMP_W'(s.rtt) << k;
                if (GCMP_W'(s.grem) >= cmp) begin
                    s.grem  = s.grem - cmp[GREM_W-1:0];
                    s.gq[k] = 1'b1;
                end
            end
            st_next[g+1] = s;
        end

        // ceiling and clamp to gain_limit; zero rtt takes gain_limit, zero target otherwise gives zero
        s     = st_reg[ST_GAIN-1];
        ceil9 = s.gsat ? (GL_W+1)'(1 << GL_W) : {1'b0, s.gq} + (GL_W+1)'(1);
        if (s.tgt == '0) begin
            ceil9 = '0;
        end
        if (s.rtt == '0 || ceil9 >= {1'b0, s.gl}) begin
            s.gain = s.gl;
        end else begin
            s.gain = ceil9[GL_W-1:0];
        end
        st_next[ST_GAIN] = s;

        s       = st_reg[ST_P1-1];
        s.acc   = ACC_W'(s.gain * s.ws);
        s.den   = DEN_W'(s.gain * s.tgt);
        st_next[ST_P1] = s;

        s       = st_reg[ST_P2-1];
        p1s     = {1'b0, s.acc[P1_W-1:0]};
        s.acc   = ACC_W'($signed(p1s) * s.diff);
        st_next[ST_P2] = s;

        // numerator, sign and magnitude, high part checked for overflow
        s       = st_reg[ST_NUM-1];
        s.acc   = $signed({{(ACC_W-TGT_W){1'b0}}, s.tgt}) - s.acc;
        s.neg   = s.acc[ACC_W-1];
        mag     = s.neg ? ACC_W'(-s.acc) : ACC_W'(s.acc);
        s.dzero = s.den == '0;
        s.qsat  = mag[ACC_W-1:QLO_W] >= QLO_W'(s.den);
        s.rem   = mag[QLO_W+DEN_W-1:QLO_W];
        s.qlo   = mag[QLO_W-1:0];
        st_next[ST_NUM] = s;

        // restoring division of |num| by den, four bits per stage
        for (int d = 0; d < DIV_STAGES; d++) begin
            s = st_reg[ST_DIV0+d-1];
            for (int j = 0; j < DIV_STEPS; j++) begin
                rem2 = {s.rem, s.qlo[QLO_W-1]};
                s.qlo = {s.qlo[QLO_W-2:0], 1'b0};
                if (rem2 >= {1'b0, s.den}) begin
                    rem2     = rem2 - {1'b0, s.den};
                    s.qlo[0] = 1'b1;
                end
                s.rem = rem2[DEN_W-1:0];
            end
            st_next[ST_DIV0+d] = s;
        end

        // sign, floor at minus half window, saturation; zero divisor gives zero
        s        = st_reg[ST_FINAL-1];
        half_mag = s.ws[WS_W-1:1];
        if (s.dzero) begin
            s.res = '0;
        end else if (!s.neg) begin
            s.res = (s.qsat || s.qlo[QLO_W-1]) ? CHG_MAX : s.qlo;
        end else if (s.qsat || s.qlo > QLO_W'(half_mag)) begin
            s.res = CHG_W'(-$signed({1'b0, half_mag}));
        end else begin
            s.res = CHG_W'(-s.qlo);
        end
        st_next[ST_FINAL] = s;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NSTAGE-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < NSTAGE; i++) begin
                st_reg[i] <= st_next[i];
            end
        end
    end

endmodule

// ===== rtl/lwd_checker.sv =====
// ----------------------------------------------------------------------------
// lwd_checker
// port-level checks for the window change pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lwd_checker
    import lwd_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic signed [CHG_W-1:0] m_window_change
);

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid, "result dropped")
    `ASSERT_NEXT(a_out_stable, aclk, aresetn, m_valid && !m_ready, $stable(m_window_change), "result changed under stall")
    `ASSERT_CLK(a_stall_blocks, aclk, aresetn, (m_valid && !m_ready) |-> !s_ready, "input taken while output stalled")
    `ASSERT_CLK(a_floor, aclk, aresetn, m_valid |-> (m_window_change >= -32'sd1073741824), "change below half window floor")

endmodule

bind ledbat_window_decrease_top lwd_checker u_lwd_checker (.*);

// ===== test/ledbat_window_decrease_top_test.sv =====
// ----------------------------------------------------------------------------
// ledbat_window_decrease_top_test
// drives ack records through the ledbat++ window change pipe under random
// stalls on both sides and checks every result against a local predictor,
// across several target_delay / gain_limit settings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ledbat_window_decrease_top_test;
    import lwd_pkg::*;

    typedef struct packed {
        logic [WIN_W-1:0]   window;
        logic [SCALE_W-1:0] scale;
        logic [QD_W-1:0]    qdelay;
        logic [RTT_W-1:0]   rtt_min;
    } ack_t;

    localparam int unsigned DRAIN_CYCLES = 30;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic                    cfg_index = 1'b0;
    logic [TGT_W-1:0]        cfg_wdata = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [WIN_W-1:0]        s_window = '0;
    logic [SCALE_W-1:0]      s_scale = '0;
    logic [QD_W-1:0]         s_qdelay = '0;
    logic [RTT_W-1:0]        s_rtt_min = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic signed [CHG_W-1:0] m_window_change;

    ack_t                    pending_acks[$];
    logic signed [CHG_W-1:0] expected_changes[$];
    logic [TGT_W-1:0]        target_delay = TARGET_RESET;
    logic [GL_W-1:0]         gain_limit = GAIN_RESET;
    bit                      calm = 1'b0;
    int                      errors = 0;

    ledbat_window_decrease_top u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_window        (s_window),
        .s_scale         (s_scale),
        .s_qdelay        (s_qdelay),
        .s_rtt_min       (s_rtt_min),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_window_change (m_window_change)
    );

    always #4 aclk = ~aclk;

    function automatic logic signed [CHG_W-1:0] window_change_of(ack_t a,
            logic [TGT_W-1:0] tgt, logic [GL_W-1:0] gl);
        longint ws, t, g, rtt, diff, num, den, chg, half;
        ws   = longint'(a.window) * longint'(a.scale);
        t    = longint'(tgt);
        rtt  = longint'({32'd0, a.rtt_min});
        if (rtt == 0) begin
            g = longint'(gl);
        end else begin
            g = (2 * t + rtt - 1) / rtt;
            if (g > longint'(gl)) g = longint'(gl);
        end
        diff = longint'(a.qdelay) - t;
        num  = t - g * ws * diff;
        den  = g * t;
        chg  = (den != 0) ? num / den : 0;
        half = -(ws / 2);
        if (chg < half) chg = half;
        if (chg > 64'sd2147483647) chg = 64'sd2147483647;
        if (chg < -64'sd2147483648) chg = -64'sd2147483648;
        return chg[CHG_W-1:0];
    endfunction

    // sender: predict on acceptance, then present the next queued ack
    always @(posedge aclk) begin
        logic next_valid;
        ack_t a;
        next_valid = s_valid;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_changes.push_back(window_change_of(
                    {s_window, s_scale, s_qdelay, s_rtt_min}, target_delay, gain_limit));
                next_valid = 1'b0;
            end
            if (!next_valid && pending_acks.size() > 0
                    && (calm || $urandom_range(99) >= 30)) begin
                a = pending_acks.pop_front();
                s_window      <= a.window;
                s_scale       <= a.scale;
                s_qdelay      <= a.qdelay;
                s_rtt_min     <= a.rtt_min;
                next_valid = 1'b1;
            end
        end
        s_valid <= next_valid;
    end

    // receiver: random back-pressure and result check
    always @(posedge aclk) begin
        logic signed [CHG_W-1:0] want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_changes.size() == 0) begin
                    $display("%0t: unexpected result %0d", $time, m_window_change);
                    errors++;
                end else begin
                    want = expected_changes.pop_front();
                    if (m_window_change !== want) begin
                        $display("%0t: window_change expected %0d actual %0d",
                                 $time, want, m_window_change);
                        errors++;
                    end
                end
            end
            m_ready <= calm || $urandom_range(99) >= 30;
        end
    end

    task automatic wait_drained();
        while (pending_acks.size() > 0 || s_valid || expected_changes.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [TGT_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        if (idx == 1'(REG_TARGET)) target_delay <= value;
        else                       gain_limit <= value[GL_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic push_ack(int unsigned w, int unsigned sc, int unsigned qd,
                            int unsigned rtt);
        ack_t a;
        a.window = WIN_W'(w); a.scale = SCALE_W'(sc); a.qdelay = QD_W'(qd);
        a.rtt_min = rtt;
        pending_acks.push_back(a);
    endtask

    // mostly realistic acks around the target, some fully random ones
    task automatic push_random(int n);
        int unsigned t;
        for (int i = 0; i < n; i++) begin
            t = 32'(target_delay);
            if ($urandom_range(3) == 0)
                push_ack($urandom, $urandom, $urandom, $urandom);
            else
                push_ack($urandom, $urandom_range(1, 16384),
                         $urandom_range(0, 4 * t + 10),
                         $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 4 * t + 10));
        end
    endtask

    initial begin
        int unsigned t;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, zero rtt, exact ceiling, on-target delay
        t = 32'(TARGET_RESET);
        push_ack(0, 1, 0, 0);
        push_ack(32'hffff, 16384, 32'hffffff, 32'hffffffff);
        push_ack(32'hffff, 32'h7fff, 32'hffffff, 0);
        push_ack(32'hffff, 32'h7fff, 0, 1);
        push_ack(1000, 0, 500, 100);
        push_ack(1000, 16, t, 100);
        push_ack(1000, 16, t + 1, 2 * t);
        push_ack(1000, 16, t - 1, 2 * t / 3);
        push_ack(1000, 16, 0, 2 * t + 1);
        push_ack(1000, 16, 0, t / 4);
        push_ack(1, 1, t + 1, 1);
        push_ack(32'hffff, 1, 0, 32'hffffffff);
        push_ack(2, 1, 32'hffffff, 7);
        push_ack(12345, 300, 1000, 0);
        push_ack(32'hffff, 16384, 0, 0);
        wait_drained();
        push_random(300);
        wait_drained();

        write_reg(1'(REG_TARGET), 16'd1);
        write_reg(1'(REG_GAIN), 16'd1);
        push_ack(32'hffff, 32'h7fff, 32'hffffff, 1);
        push_random(300);
        wait_drained();

        write_reg(1'(REG_TARGET), 16'hffff);
        write_reg(1'(REG_GAIN), 16'd255);
        push_ack(32'hffff, 32'h7fff, 32'hffffff, 0);
        push_ack(32'hffff, 32'h7fff, 0, 1);
        calm = 1'b1;
        push_random(300);
        wait_drained();
        calm = 1'b0;

        // zero divisor: target_delay of zero, then gain_limit of zero
        write_reg(1'(REG_TARGET), 16'd0);
        write_reg(1'(REG_GAIN), 16'd16);
        push_random(200);
        wait_drained();
        write_reg(1'(REG_TARGET), 16'd360);
        write_reg(1'(REG_GAIN), 16'd0);
        push_random(200);
        wait_drained();

        write_reg(1'(REG_TARGET), 16'd100);
        write_reg(1'(REG_GAIN), 16'd40);
        for (int k = 0; k < 10; k++) begin
            // sender holds off until the pipe is empty between bursts
            push_random(50);
            wait_drained();
        end

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #(8 * 300000);
        $display("Some tests failed");
        $finish;
    end

endmodule
